/* hdl/ray_ground_point_classifier_core_defines.svh */
// assertion macros for the classifier rtl, used by the queue
`ifndef RAY_GROUND_POINT_CLASSIFIER_CORE_DEFINES_SVH
`define RAY_GROUND_POINT_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RGPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgpc assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define RGPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgpc assertion failed");

`endif

/* hdl/rgpc_pkg.sv */
package rgpc_pkg;

  localparam int RADIUS_W   = 16;
  localparam int HEIGHT_W   = 16;
  localparam int LEN_W      = 12;
  localparam int TAN_W      = 16;
  localparam int GAP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // signed width that holds any Q16 height difference or threshold
  localparam int CMP_W      = 36;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [LEN_W-1:0] SENSOR_HEIGHT_RST = 12'd1800;
  localparam logic [TAN_W-1:0] LOCAL_TAN_RST     = 16'd5734;
  localparam logic [TAN_W-1:0] GLOBAL_TAN_RST    = 16'd8047;
  localparam logic [LEN_W-1:0] MIN_STEP_RST      = 12'd50;
  localparam logic [LEN_W-1:0] CONC_STEP_RST     = 12'd10;
  localparam logic [GAP_W-1:0] RECLASS_GAP_RST   = 16'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_HEIGHT = 3'd0,
    REG_LOCAL_TAN     = 3'd1,
    REG_GLOBAL_TAN    = 3'd2,
    REG_MIN_STEP      = 3'd3,
    REG_CONC_STEP     = 3'd4,
    REG_RECLASS_GAP   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic can_push;
    logic has_data;
  } q_stat_t;

endpackage

/* hdl/rgpc_ifs.sv */
interface rgpc_in_if import rgpc_pkg::*; #(parameter int INDEX_BITS = 18) ();
  logic                       valid;
  logic                       ready;
  logic [RADIUS_W-1:0]        radius_mm;
  logic signed [HEIGHT_W-1:0] height_mm;
  logic                       ray_start;
  logic [INDEX_BITS-1:0]      point_index;

  modport source(output valid, radius_mm, height_mm, ray_start, point_index, input ready);
  modport sink(input valid, radius_mm, height_mm, ray_start, point_index, output ready);
endinterface

interface rgpc_out_if #(parameter int INDEX_BITS = 18) ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] point_tag;
  logic                  is_ground;

  modport source(output valid, point_tag, is_ground, input ready);
  modport sink(input valid, point_tag, is_ground, output ready);
endinterface

interface rgpc_cfg_if import rgpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hdl/rgpc_front.sv */
module rgpc_front import rgpc_pkg::*; #(
  parameter int INDEX_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rgpc_in_if.sink               in_chan,
  rgpc_cfg_if.sink              cfg_chan,
  input  q_stat_t               q_stat,
  output logic                  q_push,
  output logic [INDEX_BITS:0]   q_data
);

  logic [LEN_W-1:0] sensor_h_r;
  logic [TAN_W-1:0] local_tan_r;
  logic [TAN_W-1:0] global_tan_r;
  logic [LEN_W-1:0] min_step_r;
  logic [LEN_W-1:0] conc_step_r;
  logic [GAP_W-1:0] gap_r;

  logic [RADIUS_W-1:0]        last_radius_r, last_radius_nxt;
  logic signed [HEIGHT_W-1:0] last_height_r, last_height_nxt;
  logic                       last_ground_r, last_ground_nxt;

  logic                       accept;
  logic [RADIUS_W-1:0]        base_radius;
  logic signed [HEIGHT_W-1:0] base_height;
  logic signed [HEIGHT_W-1:0] floor_mm;
  logic                       base_ground;
  logic signed [RADIUS_W:0]   step;
  logic signed [33:0]         thr_raw;
  logic signed [33:0]         min_thr;
  logic signed [33:0]         thr;
  logic [31:0]                gthr;
  logic signed [HEIGHT_W:0]   diff_prev;
  logic signed [HEIGHT_W:0]   diff_floor;
  logic signed [CMP_W-1:0]    dprev_q, dfloor_q, thr_q, gthr_q;
  logic                       big_step, gap_step;
  logic                       in_local, in_cone, in_floor;
  logic                       ground;

  function automatic logic in_window(logic signed [CMP_W-1:0] d,
                                     logic signed [CMP_W-1:0] t);
    in_window = (d <= t) && (d >= -t);
  endfunction

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_h_r   <= SENSOR_HEIGHT_RST;
      local_tan_r  <= LOCAL_TAN_RST;
      global_tan_r <= GLOBAL_TAN_RST;
      min_step_r   <= MIN_STEP_RST;
      conc_step_r  <= CONC_STEP_RST;
      gap_r        <= RECLASS_GAP_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_SENSOR_HEIGHT: sensor_h_r   <= cfg_chan.data[LEN_W-1:0];
        REG_LOCAL_TAN:     local_tan_r  <= cfg_chan.data[TAN_W-1:0];
        REG_GLOBAL_TAN:    global_tan_r <= cfg_chan.data[TAN_W-1:0];
        REG_MIN_STEP:      min_step_r   <= cfg_chan.data[LEN_W-1:0];
        REG_CONC_STEP:     conc_step_r  <= cfg_chan.data[LEN_W-1:0];
        REG_RECLASS_GAP:   gap_r        <= cfg_chan.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = q_stat.can_push;

  // ray start restarts the neighbour from the floor under the sensor
  assign floor_mm    = -$signed({{(HEIGHT_W-LEN_W){1'b0}}, sensor_h_r});
  assign base_radius = in_chan.ray_start ? '0 : last_radius_r;
  assign base_height = in_chan.ray_start ? floor_mm : last_height_r;
  assign base_ground = !in_chan.ray_start && last_ground_r;

  assign step    = $signed({1'b0, in_chan.radius_mm}) - $signed({1'b0, base_radius});
  assign thr_raw = $signed({1'b0, local_tan_r}) * step;
  assign gthr    = global_tan_r * in_chan.radius_mm;
  assign min_thr = $signed({6'd0, min_step_r, 16'd0});

  assign big_step = step > $signed({{(RADIUS_W+1-LEN_W){1'b0}}, conc_step_r});
  assign gap_step = $signed({step[RADIUS_W], step}) > $signed({2'b00, gap_r});
  assign thr      = (big_step && (thr_raw < min_thr)) ? min_thr : thr_raw;

  assign diff_prev  = $signed({in_chan.height_mm[HEIGHT_W-1], in_chan.height_mm})
                    - $signed({base_height[HEIGHT_W-1], base_height});
  assign diff_floor = $signed({in_chan.height_mm[HEIGHT_W-1], in_chan.height_mm})
                    - $signed({floor_mm[HEIGHT_W-1], floor_mm});

  // height differences in Q16 millimetres, same scale as the thresholds
  assign dprev_q  = $signed({{(CMP_W-HEIGHT_W-17){diff_prev[HEIGHT_W]}}, diff_prev, 16'd0});
  assign dfloor_q = $signed({{(CMP_W-HEIGHT_W-17){diff_floor[HEIGHT_W]}}, diff_floor, 16'd0});
  assign thr_q    = $signed({{(CMP_W-34){thr[33]}}, thr});
  assign gthr_q   = $signed({{(CMP_W-32){1'b0}}, gthr});

  assign in_local = in_window(dprev_q, thr_q);
  assign in_cone  = in_window(dfloor_q, gthr_q);
  assign in_floor = in_window(dfloor_q, thr_q);
  assign ground   = in_local ? (base_ground || in_cone) : (gap_step && in_floor);

  always_comb begin
    last_radius_nxt = last_radius_r;
    last_height_nxt = last_height_r;
    last_ground_nxt = last_ground_r;
    if (accept) begin
      last_radius_nxt = in_chan.radius_mm;
      last_height_nxt = in_chan.height_mm;
      last_ground_nxt = ground;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_radius_r <= '0;
      last_height_r <= -$signed({{(HEIGHT_W-LEN_W){1'b0}}, SENSOR_HEIGHT_RST});
      last_ground_r <= 1'b0;
    end else begin
      last_radius_r <= last_radius_nxt;
      last_height_r <= last_height_nxt;
      last_ground_r <= last_ground_nxt;
    end
  end

  assign q_push = accept;
  assign q_data = {in_chan.point_index, ground};

endmodule

/* hdl/rgpc_queue.sv */
`include "ray_ground_point_classifier_core_defines.svh"

module rgpc_queue import rgpc_pkg::*; #(
  parameter int WIDTH = 19
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);

  logic [WIDTH-1:0]   mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign pop_data      = mem_r[rd_ptr_r];
  assign stat.can_push = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign stat.has_data = (cnt_r != '0);

  `RGPC_ASSERT_NOW(a_no_overflow, push, cnt_r != Q_CNT_W'(Q_DEPTH))
  `RGPC_ASSERT_NOW(a_no_underflow, pop, cnt_r != '0)
  `RGPC_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1)
  `RGPC_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

/* hdl/rgpc_back.sv */
module rgpc_back import rgpc_pkg::*; #(
  parameter int INDEX_BITS = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  q_stat_t             q_stat,
  input  logic [INDEX_BITS:0] q_data,
  output logic                q_pop,
  rgpc_out_if.source          out_chan
);

  logic                  out_valid_r, out_valid_nxt;
  logic [INDEX_BITS-1:0] out_tag_r;
  logic                  out_ground_r;
  logic                  load;

  // refill the output register whenever it is empty or being drained
  assign load  = q_stat.has_data && (!out_valid_r || out_chan.ready);
  assign q_pop = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tag_r    <= q_data[INDEX_BITS:1];
      out_ground_r <= q_data[0];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.point_tag = out_tag_r;
  assign out_chan.is_ground = out_ground_r;

endmodule

/* hdl/ray_ground_point_classifier_core.sv */
// a point accepted at the input is written into the queue, then loaded into the
// output register, where it waits for the receiver; one point per cycle while the
// queue has room, the classify step is combinational through the previous point's ground flag
// a two-entry queue and an output register decouple input and result sides
// reset: synchronous active-low rst_n restores register defaults, clears the
// ray state to radius 0, height minus the default sensor height, not ground
module ray_ground_point_classifier_core import rgpc_pkg::*; #(
  parameter int INDEX_BITS = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  rgpc_in_if.sink    in_chan,
  rgpc_out_if.source out_chan,
  rgpc_cfg_if.sink   cfg_chan
);

  q_stat_t             q_stat;
  logic                q_push;
  logic                q_pop;
  logic [INDEX_BITS:0] q_wr_data;
  logic [INDEX_BITS:0] q_rd_data;

  rgpc_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  rgpc_queue #(
    .WIDTH(INDEX_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .stat      (q_stat)
  );

  rgpc_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

/* tb/tb_ray_ground_point_classifier_core.sv */
module tb_ray_ground_point_classifier_core import rgpc_pkg::*;;

  localparam int IDX_W          = 18;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 200000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [RADIUS_W-1:0]        radius;
    logic signed [HEIGHT_W-1:0] height;
    logic                       start;
    logic [IDX_W-1:0]           idx;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0] tag;
    logic             gnd;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  rgpc_in_if  #(.INDEX_BITS(IDX_W)) pt_if ();
  rgpc_out_if #(.INDEX_BITS(IDX_W)) res_if ();
  rgpc_cfg_if                       cfg_if ();

  ray_ground_point_classifier_core #(.INDEX_BITS(IDX_W)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pt_if),
    .out_chan (res_if),
    .cfg_chan (cfg_if)
  );

  always #2 clk = ~clk;

  // register copies
  logic [LEN_W-1:0] cfg_sensor = SENSOR_HEIGHT_RST;
  logic [TAN_W-1:0] cfg_local  = LOCAL_TAN_RST;
  logic [TAN_W-1:0] cfg_global = GLOBAL_TAN_RST;
  logic [LEN_W-1:0] cfg_min    = MIN_STEP_RST;
  logic [LEN_W-1:0] cfg_conc   = CONC_STEP_RST;
  logic [GAP_W-1:0] cfg_gap    = RECLASS_GAP_RST;

  // previous point of the current ray
  logic [RADIUS_W-1:0]        ray_radius = '0;
  logic signed [HEIGHT_W-1:0] ray_height = -$signed({4'b0000, SENSOR_HEIGHT_RST});
  logic                       ray_ground = 1'b0;

  point_t   point_q[$];
  verdict_t verdict_q[$];

  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int queued_n      = 0;
  int accepted_n    = 0;
  int rays_n        = 0;
  int ground_n      = 0;
  int results_n     = 0;
  int cfg_writes_n  = 0;
  int mismatches    = 0;
  bit pressure_go   = 1'b0;
  logic hold_rx     = 1'b0;

  function automatic logic in_window(longint v, longint centre, longint span);
    return v <= centre + span && v >= centre - span;
  endfunction

  function automatic logic judge_point(logic [RADIUS_W-1:0] radius,
                                       logic signed [HEIGHT_W-1:0] height, logic start);
    longint step, thr, gthr, min_thr, h_q, prev_q, floor_q;
    logic gnd;
    if (start) begin
      ray_radius = '0;
      ray_height = -$signed({4'b0000, cfg_sensor});
      ray_ground = 1'b0;
    end
    step    = longint'(radius) - longint'(ray_radius);
    thr     = longint'(cfg_local) * step;
    gthr    = longint'(cfg_global) * longint'(radius);
    min_thr = longint'(cfg_min) * 65536;
    if (step > longint'(cfg_conc) && thr < min_thr) thr = min_thr;
    h_q     = longint'(height) * 65536;
    prev_q  = longint'(ray_height) * 65536;
    floor_q = -longint'(cfg_sensor) * 65536;
    if (in_window(h_q, prev_q, thr)) begin
      gnd = ray_ground ? 1'b1 : in_window(h_q, floor_q, gthr);
    end else begin
      gnd = step > longint'(cfg_gap) && in_window(h_q, floor_q, thr);
    end
    ray_ground = gnd;
    ray_radius = radius;
    ray_height = height;
    return gnd;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SENSOR_HEIGHT: cfg_sensor = data[LEN_W-1:0];
      REG_LOCAL_TAN:     cfg_local  = data[TAN_W-1:0];
      REG_GLOBAL_TAN:    cfg_global = data[TAN_W-1:0];
      REG_MIN_STEP:      cfg_min    = data[LEN_W-1:0];
      REG_CONC_STEP:     cfg_conc   = data[LEN_W-1:0];
      REG_RECLASS_GAP:   cfg_gap    = data[GAP_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // point driver
  always @(posedge clk) begin : drv
    point_t p;
    if (!rst_n) begin
      pt_if.valid <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        accepted_n++;
        if (pt_if.ray_start) rays_n++;
        verdict_q.insert(verdict_q.size(),
                         verdict_t'{tag: pt_if.point_index,
                                    gnd: judge_point(pt_if.radius_mm, pt_if.height_mm,
                                                     pt_if.ray_start)});
      end
      if (!pt_if.valid || pt_if.ready) begin
        if (point_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          p = point_q.pop_front();
          pt_if.valid       <= 1'b1;
          pt_if.radius_mm   <= p.radius;
          pt_if.height_mm   <= p.height;
          pt_if.ray_start   <= p.start;
          pt_if.point_index <= p.idx;
        end else begin
          pt_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    verdict_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_n++;
        if (res_if.is_ground) ground_n++;
        if (verdict_q.size() == 0) begin
          flag_mismatch("unexpected result, tag", -1, res_if.point_tag);
        end else begin
          want = verdict_q.pop_front();
          if (res_if.point_tag !== want.tag) flag_mismatch("point_tag", want.tag, res_if.point_tag);
          if (res_if.is_ground !== want.gnd)
            flag_mismatch($sformatf("is_ground of tag %0d", want.tag), want.gnd, res_if.is_ground);
        end
      end
      res_if.ready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin : rx_hold
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 4);
    $display("timeout with %0d results outstanding", verdict_q.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic queue_point(int r, int h, logic s, logic [IDX_W-1:0] idx);
    point_t p;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    if (h < -32768) h = -32768;
    if (h > 32767) h = 32767;
    p.radius = r[RADIUS_W-1:0];
    p.height = h[HEIGHT_W-1:0];
    p.start  = s;
    p.idx    = idx;
    point_q.insert(point_q.size(), p);
    queued_n++;
  endtask

  task automatic queue_noise(int cnt);
    for (int k = 0; k < cnt; k++)
      queue_point($urandom_range(0, 65535), int'($urandom_range(0, 65535)) - 32768,
                  $urandom_range(0, 3) == 0, IDX_W'($urandom));
  endtask

  // one ray, radius mostly rising, mostly floor with the odd obstacle or gap
  task automatic queue_ray();
    int len, r, h, floor_h;
    len     = $urandom_range(2, 24);
    floor_h = -int'(cfg_sensor);
    r       = $urandom_range(0, 3000);
    h       = floor_h + int'($urandom_range(0, 80)) - 40;
    for (int k = 0; k < len; k++) begin
      if (k != 0) begin
        case ($urandom_range(0, 19))
          0, 1:    r += $urandom_range(150, 2500);
          2:       r -= $urandom_range(1, 300);
          3:       ;
          default: r += $urandom_range(1, 150);
        endcase
        case ($urandom_range(0, 9))
          0, 1:    ;
          2:       h = floor_h + int'($urandom_range(150, 2500));
          3:       h = floor_h + int'($urandom_range(0, 20)) - 10;
          default: h += int'($urandom_range(0, 30)) - 15;
        endcase
      end
      queue_point(r, h, k == 0, IDX_W'($urandom));
    end
  endtask

  task automatic run_random(int n);
    int goal;
    goal = queued_n + n;
    while (queued_n < goal) begin
      if ($urandom_range(0, 9) < 8) queue_ray();
      else queue_noise($urandom_range(1, 4));
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (point_q.size() != 0 || pt_if.valid || verdict_q.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk);
    while (!cfg_if.ready);
    apply_reg(idx, data);
    cfg_if.valid <= 1'b0;
    cfg_writes_n++;
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] data);
    write_reg(REG_SENSOR_HEIGHT, data);
    write_reg(REG_LOCAL_TAN, data);
    write_reg(REG_GLOBAL_TAN, data);
    write_reg(REG_MIN_STEP, data);
    write_reg(REG_CONC_STEP, data);
    write_reg(REG_RECLASS_GAP, data);
  endtask

  // plausible mounting values; upper bits of the 12-bit registers are junk
  task automatic write_plausible();
    write_reg(REG_SENSOR_HEIGHT, {4'($urandom), 12'($urandom_range(300, 3500))});
    write_reg(REG_LOCAL_TAN, 16'($urandom_range(0, 20000)));
    write_reg(REG_GLOBAL_TAN, 16'($urandom_range(0, 30000)));
    write_reg(REG_MIN_STEP, {4'($urandom), 12'($urandom_range(0, 200))});
    write_reg(REG_CONC_STEP, {4'($urandom), 12'($urandom_range(0, 100))});
    write_reg(REG_RECLASS_GAP, 16'($urandom_range(0, 1000)));
  endtask

  initial begin : stim
    pt_if.valid       = 1'b0;
    pt_if.radius_mm   = '0;
    pt_if.height_mm   = '0;
    pt_if.ray_start   = 1'b0;
    pt_if.point_index = '0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    rst_n             = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed points under the default registers
    queue_point(0, -1800, 1'b0, '0);            // state straight out of reset
    queue_point(100, -1795, 1'b0, '1);          // minimum threshold kicks in
    queue_point(110, -1795, 1'b0, 18'h2aaaa);   // step equal to concentric step
    queue_point(65535, -1800, 1'b0, 18'h15555); // huge gap, back on the floor
    queue_point(65535, -1800, 1'b0, 18'd4);     // zero step
    queue_point(65535, 32767, 1'b1, 18'd5);     // new ray, top of range
    queue_point(65535, -32768, 1'b0, 18'd6);
    queue_point(0, 0, 1'b1, 18'd7);             // new ray at the sensor itself
    queue_point(50, -1800, 1'b1, 18'd8);
    queue_point(20, -1800, 1'b0, 18'd9);        // radius going backwards
    queue_point(1000, -1600, 1'b1, 18'd10);     // outside both windows, far enough to reclass but off the floor
    queue_point(1400, -1790, 1'b0, 18'd11);     // floor again after the gap
    queue_point(1410, -1790, 1'b0, 18'd12);
    queue_point(3000, -1600, 1'b1, 18'd13);     // inside the global cone
    queue_point(3050, -1200, 1'b0, 18'd14);     // obstacle edge
    queue_point(3100, -1195, 1'b0, 18'd15);     // on the obstacle, outside the cone
    queue_point(3100, -1800, 1'b1, 18'd16);
    queue_point(65535, -1800, 1'b0, 18'd17);
    run_random(320);
    drain();

    send_idle_pct = 56;
    write_plausible();
    run_random(320);
    drain();

    send_idle_pct = 0;
    rx_stall_pct  = 56;
    write_all('1);
    run_random(320);
    drain();

    send_idle_pct = 13;
    rx_stall_pct  = 13;
    write_all('0);
    run_random(320);
    drain();

    send_idle_pct = 0;
    rx_stall_pct  = 0;
    write_plausible();
    pressure_go = 1'b1;
    run_random(320);
    drain();

    send_idle_pct = 13;
    rx_stall_pct  = 13;
    write_plausible();
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    run_random(320);
    drain();

    $display("checked %0d points over %0d rays (%0d ground), %0d register writes",
             accepted_n, rays_n, ground_n, cfg_writes_n);
    $display("register sets: defaults, random, all ones, all zeros, receiver hold-off, spare indexes");
    if (mismatches == 0 && verdict_q.size() == 0 && results_n == accepted_n) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, verdict_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
